### rtl/gdod_pkg.sv
// Shared types, constants and month length lookup for the Gregorian date unit.
`default_nettype none
package gdod_pkg;

    localparam int YEAR_W          = 14;
    localparam int MONTH_W         = 4;
    localparam int DAY_W           = 5;
    localparam int DIFF_W          = 23;
    localparam int STATUS_W        = 2;
    localparam int DEF_MAX_YEAR    = 9999;
    localparam int DEF_OFFSET_BITS = 21;
    localparam int DAYS_YEAR       = 365;
    localparam int C100            = 100;
    localparam int C400            = 400;

    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR  = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN  = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP  = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV  = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]   LEN_LONG   = 5'd31;
    localparam logic [DAY_W-1:0]   LEN_SHORT  = 5'd30;
    localparam logic [DAY_W-1:0]   LEN_FEB    = 5'd28;
    localparam logic [DAY_W-1:0]   LEN_FEB_LP = 5'd29;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRECHK,
        S_YEAR,
        S_MONTH,
        S_DAY,
        S_WALK,
        S_FIN,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_SET_INVALID,
        OP_MONTH_INIT,
        OP_YEAR_STEP,
        OP_MONTH_STEP,
        OP_DAY_ACC,
        OP_WALK_INIT,
        OP_WALK_STEP,
        OP_SET_DIFF
    } t_op;

    typedef struct packed {
        logic func;
        logic pre_bad;
        logic year_hit;
        logic month_hit;
        logic day_bad;
        logic sel_b;
        logic walk_end;
    } t_flags;

    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            MONTH_FEB: len = leap ? LEN_FEB_LP : LEN_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
            default: len = LEN_LONG;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

### rtl/gdod_seq.sv
// Sequencer for the date unit: walks the year, month, day and offset phases.
`default_nettype none
module gdod_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic            i_ready,
    input  wire gdod_pkg::t_flags i_flags,
    output gdod_pkg::t_op        o_op,
    output logic                 o_ready,
    output logic                 o_valid
);
    import gdod_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_PRECHK;
            S_PRECHK: n_state = i_flags.pre_bad ? S_OUT : S_YEAR;
            S_YEAR:   if (i_flags.year_hit) n_state = S_MONTH;
            S_MONTH:  if (i_flags.month_hit) n_state = S_DAY;
            S_DAY: begin
                priority if (i_flags.day_bad) n_state = S_OUT;
                else if (!i_flags.func) n_state = S_WALK;
                else if (!i_flags.sel_b) n_state = S_YEAR;
                else n_state = S_FIN;
            end
            S_WALK:   if (i_flags.walk_end) n_state = S_OUT;
            S_FIN:    n_state = S_OUT;
            S_OUT:    if (i_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_op    = OP_NONE;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) o_op = OP_LOAD;
            end
            S_PRECHK: o_op = i_flags.pre_bad ? OP_SET_INVALID : OP_INIT;
            S_YEAR:   o_op = i_flags.year_hit ? OP_MONTH_INIT : OP_YEAR_STEP;
            S_MONTH:  o_op = i_flags.month_hit ? OP_NONE : OP_MONTH_STEP;
            S_DAY: begin
                priority if (i_flags.day_bad) o_op = OP_SET_INVALID;
                else if (!i_flags.func) o_op = OP_WALK_INIT;
                else o_op = OP_DAY_ACC;
            end
            S_WALK:   o_op = OP_WALK_STEP;
            S_FIN:    o_op = OP_SET_DIFF;
            S_OUT:    o_valid = 1'b1;
            default:  o_op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

### rtl/gdod_dp.sv
// Datapath for the date unit: one shared adder, year and month counters, result regs.
`default_nettype none
module gdod_dp #(
    parameter int MAX_YEAR    = gdod_pkg::DEF_MAX_YEAR,
    parameter int OFFSET_BITS = gdod_pkg::DEF_OFFSET_BITS
) (
    input  wire logic                            i_clk,
    input  wire gdod_pkg::t_op                   i_op,
    input  wire logic                            i_func,
    input  wire logic [gdod_pkg::YEAR_W-1:0]     i_year_a,
    input  wire logic [gdod_pkg::MONTH_W-1:0]    i_month_a,
    input  wire logic [gdod_pkg::DAY_W-1:0]      i_day_a,
    input  wire logic [gdod_pkg::YEAR_W-1:0]     i_year_b,
    input  wire logic [gdod_pkg::MONTH_W-1:0]    i_month_b,
    input  wire logic [gdod_pkg::DAY_W-1:0]      i_day_b,
    input  wire logic signed [OFFSET_BITS-1:0]   i_day_offset,
    output gdod_pkg::t_flags                     o_flags,
    output logic [gdod_pkg::YEAR_W-1:0]          o_res_year,
    output logic [gdod_pkg::MONTH_W-1:0]         o_res_month,
    output logic [gdod_pkg::DAY_W-1:0]           o_res_day,
    output logic signed [gdod_pkg::DIFF_W-1:0]   o_day_difference,
    output logic [gdod_pkg::STATUS_W-1:0]        o_status
);
    import gdod_pkg::*;

    localparam int YW = ($clog2(MAX_YEAR + 1) > YEAR_W) ? $clog2(MAX_YEAR + 1) : YEAR_W;
    localparam int AW = (OFFSET_BITS + 2 > 25) ? OFFSET_BITS + 2 : 25;
    localparam logic [YW-1:0] MAX_Y = YW'(MAX_YEAR);
    localparam logic [6:0] C100_TOP = 7'(C100 - 1);
    localparam logic [8:0] C400_TOP = 9'(C400 - 1);

    logic                   r_func, n_func;
    logic [YEAR_W-1:0]      r_ya, n_ya, r_yb, n_yb;
    logic [MONTH_W-1:0]     r_ma, n_ma, r_mb, n_mb;
    logic [DAY_W-1:0]       r_da, n_da, r_db, n_db;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [YW-1:0]          r_y, n_y;
    logic [MONTH_W-1:0]     r_m, n_m;
    logic [DAY_W-1:0]       r_d, n_d;
    logic [6:0]             r_c100, n_c100;
    logic [8:0]             r_c400, n_c400;
    logic [AW-1:0]          r_acc, n_acc;
    logic                   r_sel_b, n_sel_b;
    logic [YEAR_W-1:0]      r_res_year, n_res_year;
    logic [MONTH_W-1:0]     r_res_month, n_res_month;
    logic [DAY_W-1:0]       r_res_day, n_res_day;
    logic [DIFF_W-1:0]      r_diff, n_diff;
    t_status                r_status, n_status;

    logic [YEAR_W-1:0]  y_tgt;
    logic [MONTH_W-1:0] m_tgt;
    logic [DAY_W-1:0]   d_tgt;
    logic               leap;
    logic [DAY_W-1:0]   mlen_cur, mlen_tgt, mlen_prev;
    logic               fwd;
    logic [5:0]         rem1;
    logic [8:0]         mag;
    logic               neg;
    logic [AW-1:0]      opnd, sum;
    logic               end_ok, oor, fits;
    logic [6:0]         c100_inc, c100_dec;
    logic [8:0]         c400_inc, c400_dec;
    logic               bad_a, bad_b;

    assign y_tgt = r_sel_b ? r_yb : r_ya;
    assign m_tgt = r_sel_b ? r_mb : r_ma;
    assign d_tgt = r_sel_b ? r_db : r_da;

    assign leap      = ((r_y[1:0] == 2'd0) && (r_c100 != 7'd0)) || (r_c400 == 9'd0);
    assign mlen_cur  = f_month_len(r_m, leap);
    assign mlen_tgt  = f_month_len(m_tgt, leap);
    assign mlen_prev = f_month_len(r_m - 4'd1, leap);
    assign fwd       = ~r_acc[AW-1];
    assign rem1      = 6'(mlen_cur) - 6'(r_d) + 6'd1;

    assign c100_inc = (r_c100 == C100_TOP) ? 7'd0 : r_c100 + 7'd1;
    assign c100_dec = (r_c100 == 7'd0) ? C100_TOP : r_c100 - 7'd1;
    assign c400_inc = (r_c400 == C400_TOP) ? 9'd0 : r_c400 + 9'd1;
    assign c400_dec = (r_c400 == 9'd0) ? C400_TOP : r_c400 - 9'd1;

    // shared adder operand
    always_comb begin
        mag = 9'd0;
        neg = 1'b0;
        unique case (i_op)
            OP_YEAR_STEP: begin
                mag = 9'(DAYS_YEAR) + 9'(leap);
                neg = r_sel_b;
            end
            OP_MONTH_STEP: begin
                mag = 9'(mlen_cur);
                neg = r_sel_b;
            end
            OP_DAY_ACC: begin
                mag = 9'(d_tgt);
                neg = r_sel_b;
            end
            OP_WALK_STEP: begin
                mag = fwd ? 9'(rem1) : 9'(r_d);
                neg = fwd;
            end
            default: begin
                mag = 9'd0;
                neg = 1'b0;
            end
        endcase
    end

    assign opnd = neg ? -AW'(mag) : AW'(mag);
    assign sum  = r_acc + opnd;

    assign end_ok = fwd ? sum[AW-1] : (~sum[AW-1] && (sum != '0));
    assign oor    = ~end_ok && (fwd ? ((r_m == MONTH_DEC) && (r_y == MAX_Y))
                                    : ((r_m == MONTH_JAN) && (r_y == '0)));
    assign fits   = (r_acc[AW-1:DIFF_W-1] == '0) || (r_acc[AW-1:DIFF_W-1] == '1);

    assign bad_a = (YW'(r_ya) > MAX_Y) || (r_ma == 4'd0) || (r_ma > MONTH_DEC)
                || (r_da == 5'd0);
    assign bad_b = (YW'(r_yb) > MAX_Y) || (r_mb == 4'd0) || (r_mb > MONTH_DEC)
                || (r_db == 5'd0);

    assign o_flags.func      = r_func;
    assign o_flags.pre_bad   = bad_a || (r_func && bad_b);
    assign o_flags.year_hit  = (r_y == YW'(y_tgt));
    assign o_flags.month_hit = (r_m == m_tgt);
    assign o_flags.day_bad   = (d_tgt > mlen_tgt);
    assign o_flags.sel_b     = r_sel_b;
    assign o_flags.walk_end  = end_ok || oor;

    always_comb begin
        n_func      = r_func;
        n_ya        = r_ya;
        n_ma        = r_ma;
        n_da        = r_da;
        n_yb        = r_yb;
        n_mb        = r_mb;
        n_db        = r_db;
        n_off       = r_off;
        n_y         = r_y;
        n_m         = r_m;
        n_d         = r_d;
        n_c100      = r_c100;
        n_c400      = r_c400;
        n_acc       = r_acc;
        n_sel_b     = r_sel_b;
        n_res_year  = r_res_year;
        n_res_month = r_res_month;
        n_res_day   = r_res_day;
        n_diff      = r_diff;
        n_status    = r_status;
        unique case (i_op)
            OP_LOAD: begin
                n_func = i_func;
                n_ya   = i_year_a;
                n_ma   = i_month_a;
                n_da   = i_day_a;
                n_yb   = i_year_b;
                n_mb   = i_month_b;
                n_db   = i_day_b;
                n_off  = i_day_offset;
            end
            OP_INIT: begin
                n_y     = '0;
                n_c100  = 7'd0;
                n_c400  = 9'd0;
                n_acc   = '0;
                n_sel_b = 1'b0;
            end
            OP_SET_INVALID: begin
                n_res_year  = '0;
                n_res_month = '0;
                n_res_day   = '0;
                n_diff      = '0;
                n_status    = ST_INVALID;
            end
            OP_MONTH_INIT: n_m = MONTH_JAN;
            OP_YEAR_STEP: begin
                n_acc  = sum;
                n_y    = r_y + 1'b1;
                n_c100 = c100_inc;
                n_c400 = c400_inc;
            end
            OP_MONTH_STEP: begin
                n_acc = sum;
                n_m   = r_m + 4'd1;
            end
            OP_DAY_ACC: begin
                n_acc = sum;
                if (!r_sel_b) begin
                    n_sel_b = 1'b1;
                    n_y     = '0;
                    n_c100  = 7'd0;
                    n_c400  = 9'd0;
                end
            end
            OP_WALK_INIT: begin
                n_acc = AW'($signed(r_off));
                n_d   = r_da;
            end
            OP_WALK_STEP: begin
                priority if (oor) begin
                    n_res_year  = '0;
                    n_res_month = '0;
                    n_res_day   = '0;
                    n_diff      = '0;
                    n_status    = ST_RANGE;
                end else if (end_ok) begin
                    n_res_year  = r_y[YEAR_W-1:0];
                    n_res_month = r_m;
                    n_res_day   = fwd ? (r_d + r_acc[DAY_W-1:0]) : sum[DAY_W-1:0];
                    n_diff      = '0;
                    n_status    = ST_OK;
                end else if (fwd) begin
                    n_acc = sum;
                    n_d   = 5'd1;
                    if (r_m == MONTH_DEC) begin
                        n_m    = MONTH_JAN;
                        n_y    = r_y + 1'b1;
                        n_c100 = c100_inc;
                        n_c400 = c400_inc;
                    end else begin
                        n_m = r_m + 4'd1;
                    end
                end else begin
                    n_acc = sum;
                    if (r_m == MONTH_JAN) begin
                        n_m    = MONTH_DEC;
                        n_d    = LEN_LONG;
                        n_y    = r_y - 1'b1;
                        n_c100 = c100_dec;
                        n_c400 = c400_dec;
                    end else begin
                        n_m = r_m - 4'd1;
                        n_d = mlen_prev;
                    end
                end
            end
            OP_SET_DIFF: begin
                n_res_year  = '0;
                n_res_month = '0;
                n_res_day   = '0;
                n_diff      = fits ? r_acc[DIFF_W-1:0] : '0;
                n_status    = fits ? ST_OK : ST_RANGE;
            end
            default: begin
                n_func = r_func;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_ya        <= n_ya;
        r_ma        <= n_ma;
        r_da        <= n_da;
        r_yb        <= n_yb;
        r_mb        <= n_mb;
        r_db        <= n_db;
        r_off       <= n_off;
        r_y         <= n_y;
        r_m         <= n_m;
        r_d         <= n_d;
        r_c100      <= n_c100;
        r_c400      <= n_c400;
        r_acc       <= n_acc;
        r_sel_b     <= n_sel_b;
        r_res_year  <= n_res_year;
        r_res_month <= n_res_month;
        r_res_day   <= n_res_day;
        r_diff      <= n_diff;
        r_status    <= n_status;
    end

    assign o_res_year       = r_res_year;
    assign o_res_month      = r_res_month;
    assign o_res_day        = r_res_day;
    assign o_day_difference = $signed(r_diff);
    assign o_status         = r_status;

endmodule
`default_nettype wire

### rtl/gregorian_date_offset_and_difference_top.sv
// Difference mode counts years and months up to date a, then up to date b; offset mode
// counts up to date a, then walks the date a month at a time; a bad month, day 0 or year
// past MAX_YEAR is answered as invalid in the pre-check state.
// Throughput: one item at a time; ready is high only while idle, the next item
// is taken the cycle after the result beat is accepted.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle; datapath regs hold no reset.
`default_nettype none
module gregorian_date_offset_and_difference_top #(
    parameter int MAX_YEAR    = gdod_pkg::DEF_MAX_YEAR,
    parameter int OFFSET_BITS = gdod_pkg::DEF_OFFSET_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_func,
    input  wire logic [gdod_pkg::YEAR_W-1:0]     i_year_a,
    input  wire logic [gdod_pkg::MONTH_W-1:0]    i_month_a,
    input  wire logic [gdod_pkg::DAY_W-1:0]      i_day_a,
    input  wire logic [gdod_pkg::YEAR_W-1:0]     i_year_b,
    input  wire logic [gdod_pkg::MONTH_W-1:0]    i_month_b,
    input  wire logic [gdod_pkg::DAY_W-1:0]      i_day_b,
    input  wire logic signed [OFFSET_BITS-1:0]   i_day_offset,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [gdod_pkg::YEAR_W-1:0]          o_res_year,
    output logic [gdod_pkg::MONTH_W-1:0]         o_res_month,
    output logic [gdod_pkg::DAY_W-1:0]           o_res_day,
    output logic signed [gdod_pkg::DIFF_W-1:0]   o_day_difference,
    output logic [gdod_pkg::STATUS_W-1:0]        o_status
);
    import gdod_pkg::*;

    t_op    op;
    t_flags flags;

    gdod_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .i_flags (flags),
        .o_op    (op),
        .o_ready (o_ready),
        .o_valid (o_valid)
    );

    gdod_dp #(
        .MAX_YEAR    (MAX_YEAR),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_op             (op),
        .i_func           (i_func),
        .i_year_a         (i_year_a),
        .i_month_a        (i_month_a),
        .i_day_a          (i_day_a),
        .i_year_b         (i_year_b),
        .i_month_b        (i_month_b),
        .i_day_b          (i_day_b),
        .i_day_offset     (i_day_offset),
        .o_flags          (flags),
        .o_res_year       (o_res_year),
        .o_res_month      (o_res_month),
        .o_res_day        (o_res_day),
        .o_day_difference (o_day_difference),
        .o_status         (o_status)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("ready and result valid high together");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("still ready after input beat");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |->
        ((o_res_year == '0) && (o_res_month == '0) && (o_res_day == '0)
         && (o_day_difference == '0)))
        else $error("result fields not cleared on error status");

    a_date_xor_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_OK) && (o_res_month != '0)) |->
        ((o_day_difference == '0) && (o_res_month <= MONTH_DEC) && (o_res_day != '0)))
        else $error("date result malformed");

endmodule
`default_nettype wire
